// ===== hdl/lpht_pkg.sv =====
// shared types and constants for the linear probing hash table
`default_nettype none
package lpht_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int SIZE_W = IDX_W + 1;
  localparam int KEY_W = 31;
  localparam int CFG_W = 9;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_READ      = 3'd4
  } status_t;

  // classified operation handed from front to back
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] home;
    logic [SIZE_W-1:0] size;
    logic [7:0]       read_slot;
    logic             read_oob;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       slot;
    logic [KEY_W-1:0] entry_key;
    logic             entry_valid;
  } res_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_CLEAR,
    BS_PROBE,
    BS_WAIT,
    BS_CHECK,
    BS_OUT
  } back_state_t;
endpackage
`default_nettype wire

// ===== hdl/lpht_ram.sv =====
// generic single port write, single port registered read ram
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/lpht_front.sv =====
// front end: accepts items, computes home slot by restoring division
`default_nettype none
module lpht_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [lpht_pkg::SIZE_W-1:0]  eff_size,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_mode,
  input  wire logic [lpht_pkg::KEY_W-1:0]   in_key,
  input  wire logic [7:0]                   in_read_slot,
  output logic                              cmd_valid,
  input  wire logic                         cmd_ready,
  output lpht_pkg::cmd_t                    cmd
);
  localparam int KW = lpht_pkg::KEY_W;
  localparam int SW = lpht_pkg::SIZE_W;
  localparam int CW = $clog2(KW + 1);

  lpht_pkg::front_state_t state, state_next;
  lpht_pkg::cmd_t hold;
  logic [KW-1:0] quo;
  logic [SW:0] rem;
  logic [CW-1:0] cnt;
  logic [SW:0] trial;

  assign trial = {rem[SW-1:0], quo[KW-1]};
  assign cmd = hold;

  // next state and handshakes
  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd_valid = 1'b0;
    case (state)
      lpht_pkg::FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = in_mode[1] ? lpht_pkg::FS_PUSH : lpht_pkg::FS_DIV;
        end
      end
      lpht_pkg::FS_DIV: begin
        if (cnt == CW'(KW - 1)) begin
          state_next = lpht_pkg::FS_PUSH;
        end
      end
      lpht_pkg::FS_PUSH: begin
        cmd_valid = 1'b1;
        if (cmd_ready) begin
          state_next = lpht_pkg::FS_IDLE;
        end
      end
      default: state_next = lpht_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpht_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture and one quotient bit per cycle
  always_ff @(posedge clk) begin
    case (state)
      lpht_pkg::FS_IDLE: begin
        if (in_valid) begin
          hold.op <= in_mode[1] ? lpht_pkg::OP_READ :
                     (in_mode[0] ? lpht_pkg::OP_SEARCH : lpht_pkg::OP_INSERT);
          hold.key <= in_key;
          hold.size <= eff_size;
          hold.read_slot <= in_read_slot;
          hold.read_oob <= 32'(in_read_slot) >= lpht_pkg::TABLE_DEPTH;
          hold.home <= '0;
          quo <= in_key;
          rem <= '0;
          cnt <= '0;
        end
      end
      lpht_pkg::FS_DIV: begin
        cnt <= cnt + 1'b1;
        quo <= {quo[KW-2:0], 1'b0};
        if (trial >= {1'b0, hold.size}) begin
          rem <= trial - {1'b0, hold.size};
        end else begin
          rem <= trial;
        end
        if (cnt == CW'(KW - 1)) begin
          hold.home <= (trial >= {1'b0, hold.size}) ?
                       lpht_pkg::IDX_W'(trial - {1'b0, hold.size}) :
                       lpht_pkg::IDX_W'(trial);
        end
      end
      default: ;
    endcase
  end

  // home slot always lies below the captured size
  assert property (@(posedge clk) disable iff (rst)
    (state == lpht_pkg::FS_PUSH && hold.op != lpht_pkg::OP_READ) |->
      ({1'b0, hold.home} < hold.size))
    else $error("home slot out of range");
  assert property (@(posedge clk) disable iff (rst)
    (state == lpht_pkg::FS_PUSH && !cmd_ready) |=> state == lpht_pkg::FS_PUSH)
    else $error("command dropped");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == lpht_pkg::FS_IDLE)
    else $error("ready while busy");
endmodule
`default_nettype wire

// ===== hdl/lpht_queue.sv =====
// short fifo between front and back
`default_nettype none
module lpht_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire lpht_pkg::cmd_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output lpht_pkg::cmd_t      pop_data
);
  localparam int D = lpht_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);

  lpht_pkg::cmd_t slots [D];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0] count;
  logic do_push, do_pop;

  assign push_ready = count != (PW+1)'(D);
  assign pop_valid = count != '0;
  assign pop_data = slots[rptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(D - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(D - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (PW+1)'(D))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0 && !do_push) |=> count == '0)
    else $error("queue count moved");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("push not counted");
endmodule
`default_nettype wire

// ===== hdl/lpht_back.sv =====
// back end: clears the table after reset, probes slots and forms results
`default_nettype none
module lpht_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire lpht_pkg::cmd_t cmd,
  output logic                res_valid,
  input  wire logic           res_ready,
  output lpht_pkg::res_t      res
);
  localparam int IW = lpht_pkg::IDX_W;
  localparam int SW = lpht_pkg::SIZE_W;
  localparam int KW = lpht_pkg::KEY_W;

  lpht_pkg::back_state_t state, state_next;
  lpht_pkg::cmd_t cur;
  logic [IW-1:0] idx, clr;
  logic [SW-1:0] steps;
  logic [KW:0] rdata;
  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [KW:0] wdata;
  logic last_step;
  logic [IW-1:0] idx_inc;

  lpht_ram #(.WIDTH(KW + 1), .DEPTH(lpht_pkg::TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign last_step = (steps + 1'b1) == cur.size;
  assign idx_inc = ({1'b0, idx} + 1'b1 >= cur.size) ? '0 : idx + 1'b1;
  assign cmd_ready = state == lpht_pkg::BS_IDLE;
  assign res_valid = state == lpht_pkg::BS_OUT;

  // read address, write port and next state
  always_comb begin
    state_next = state;
    raddr = idx;
    we = 1'b0;
    waddr = idx;
    wdata = {1'b1, cur.key};
    case (state)
      lpht_pkg::BS_CLEAR: begin
        we = 1'b1;
        waddr = clr;
        wdata = '0;
        if (clr == IW'(lpht_pkg::TABLE_DEPTH - 1)) begin
          state_next = lpht_pkg::BS_IDLE;
        end
      end
      lpht_pkg::BS_IDLE: begin
        if (cmd_valid) begin
          state_next = lpht_pkg::BS_WAIT;
        end
      end
      lpht_pkg::BS_PROBE: state_next = lpht_pkg::BS_WAIT;
      lpht_pkg::BS_WAIT: state_next = lpht_pkg::BS_CHECK;
      lpht_pkg::BS_CHECK: begin
        if (cur.op == lpht_pkg::OP_READ) begin
          state_next = lpht_pkg::BS_OUT;
        end else if (cur.op == lpht_pkg::OP_INSERT && !rdata[KW]) begin
          we = 1'b1;
          state_next = lpht_pkg::BS_OUT;
        end else if (cur.op == lpht_pkg::OP_SEARCH && rdata[KW] &&
                     rdata[KW-1:0] == cur.key) begin
          state_next = lpht_pkg::BS_OUT;
        end else if (last_step) begin
          state_next = lpht_pkg::BS_OUT;
        end else begin
          state_next = lpht_pkg::BS_PROBE;
        end
      end
      lpht_pkg::BS_OUT: begin
        if (res_ready) begin
          state_next = lpht_pkg::BS_IDLE;
        end
      end
      default: state_next = lpht_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpht_pkg::BS_CLEAR;
      clr <= '0;
    end else begin
      state <= state_next;
      if (state == lpht_pkg::BS_CLEAR) begin
        clr <= clr + 1'b1;
      end
    end
  end

  // probe walk and result register
  always_ff @(posedge clk) begin
    case (state)
      lpht_pkg::BS_IDLE: begin
        if (cmd_valid) begin
          cur <= cmd;
          steps <= '0;
          idx <= (cmd.op == lpht_pkg::OP_READ) ? IW'(cmd.read_slot) : cmd.home;
        end
      end
      lpht_pkg::BS_CHECK: begin
        idx <= idx_inc;
        steps <= steps + 1'b1;
        if (cur.op == lpht_pkg::OP_READ) begin
          res.status <= lpht_pkg::ST_READ;
          res.slot <= cur.read_slot;
          res.entry_valid <= rdata[KW] && !cur.read_oob;
          res.entry_key <= (rdata[KW] && !cur.read_oob) ? rdata[KW-1:0] : '0;
        end else if (cur.op == lpht_pkg::OP_INSERT && !rdata[KW]) begin
          res.status <= lpht_pkg::ST_INSERTED;
          res.slot <= 8'(idx);
          res.entry_key <= cur.key;
          res.entry_valid <= 1'b1;
        end else if (cur.op == lpht_pkg::OP_SEARCH && rdata[KW] &&
                     rdata[KW-1:0] == cur.key) begin
          res.status <= lpht_pkg::ST_FOUND;
          res.slot <= 8'(idx);
          res.entry_key <= cur.key;
          res.entry_valid <= 1'b1;
        end else begin
          res.status <= (cur.op == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL :
                        lpht_pkg::ST_NOT_FOUND;
          res.slot <= '0;
          res.entry_key <= '0;
          res.entry_valid <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == lpht_pkg::BS_OUT && !res_ready) |=> $stable(res))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (state == lpht_pkg::BS_CHECK && cur.op != lpht_pkg::OP_READ) |->
      ({1'b0, idx} < cur.size))
    else $error("probe beyond table size");
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == lpht_pkg::ST_FULL) |-> !res.entry_valid)
    else $error("full result marked valid");
endmodule
`default_nettype wire

// ===== hdl/linear_probe_hash_table_top.sv =====
// top level of the linear probing hash table
// After reset the back end clears its 256 slots, one a cycle, and hands out no
// result before the clear is done; the front end and the two-entry queue still
// take items meanwhile until the queue fills. In the front end an insert or a
// search is taken in, runs a restoring division that yields the home slot one
// key bit per cycle, and is pushed as a command, which waits while the queue is
// full; a read skips the division. The back end takes a command in its idle
// state, passes the probe, wait and check states per probed slot (the first
// goes from idle straight to wait, which covers the slot memory's registered
// read) and holds the result in its output state until taken. The queue lets
// the front work on the next item while the back probes.
`default_nettype none
module linear_probe_hash_table_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // mode[1:0], key[32:2], read_slot[40:33], zero fill
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], slot[10:3], entry_key[41:11], entry_valid[42], zero fill
  output logic [47:0]      m_axis_tdata
);
  logic [lpht_pkg::CFG_W-1:0] table_size;
  logic [lpht_pkg::SIZE_W-1:0] eff_size;
  logic f_valid, f_ready, q_valid, q_ready;
  lpht_pkg::cmd_t f_cmd, q_cmd;
  lpht_pkg::res_t res;

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= lpht_pkg::CFG_W'(256);
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  // clamp size to one through table depth
  always_comb begin
    if (table_size == '0) begin
      eff_size = lpht_pkg::SIZE_W'(1);
    end else if (32'(table_size) > lpht_pkg::TABLE_DEPTH) begin
      eff_size = lpht_pkg::SIZE_W'(lpht_pkg::TABLE_DEPTH);
    end else begin
      eff_size = lpht_pkg::SIZE_W'(table_size);
    end
  end

  lpht_front u_front (
    .clk(clk), .rst(rst), .eff_size(eff_size),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_mode(s_axis_tdata[1:0]), .in_key(s_axis_tdata[32:2]),
    .in_read_slot(s_axis_tdata[40:33]),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  lpht_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_cmd),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_cmd)
  );

  lpht_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {5'd0, res.entry_valid, res.entry_key, res.slot, res.status};
endmodule
`default_nettype wire

// ===== verif/lpht_checker.sv =====
// checker for the linear probing hash table: predicts and compares results
`timescale 1ns / 1ps
module lpht_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,
  output int               fail_count,
  output int               pending_count
);
  // shadow copy of the table
  logic [lpht_pkg::KEY_W-1:0] shadow_keys [lpht_pkg::TABLE_DEPTH];
  logic                       shadow_used [lpht_pkg::TABLE_DEPTH];
  logic [8:0]                 size_reg;
  lpht_pkg::res_t             expected_results [$];

  assign pending_count = expected_results.size();

  // one lookup against the shadow table, updating it on insert
  function automatic lpht_pkg::res_t hash_lookup(logic [1:0] mode,
                                                 logic [lpht_pkg::KEY_W-1:0] key,
                                                 logic [7:0] rslot);
    lpht_pkg::res_t r;
    int n;
    int idx;
    n = (size_reg == 0) ? 1 : (size_reg > lpht_pkg::TABLE_DEPTH ?
                                lpht_pkg::TABLE_DEPTH : int'(size_reg));
    idx = int'(key % n);
    r = '0;
    if (mode[1]) begin
      r.status = lpht_pkg::ST_READ;
      r.slot = rslot;
      if (shadow_used[rslot]) begin
        r.entry_key = shadow_keys[rslot];
        r.entry_valid = 1'b1;
      end
      return r;
    end
    for (int i = 0; i < n; i++) begin
      if (mode == lpht_pkg::OP_INSERT) begin
        if (!shadow_used[idx]) begin
          shadow_used[idx] = 1'b1;
          shadow_keys[idx] = key;
          r.status = lpht_pkg::ST_INSERTED;
          r.slot = 8'(idx);
          r.entry_key = key;
          r.entry_valid = 1'b1;
          return r;
        end
      end else if (shadow_used[idx] && shadow_keys[idx] == key) begin
        r.status = lpht_pkg::ST_FOUND;
        r.slot = 8'(idx);
        r.entry_key = key;
        r.entry_valid = 1'b1;
        return r;
      end
      idx = (idx + 1 >= n) ? 0 : idx + 1;
    end
    r.status = (mode == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
    return r;
  endfunction

  // watch channels at each rising edge
  always @(posedge clk) begin
    lpht_pkg::res_t got;
    lpht_pkg::res_t exp_r;
    logic bad;
    if (rst) begin
      size_reg <= 9'd256;
      for (int i = 0; i < lpht_pkg::TABLE_DEPTH; i++) begin
        shadow_used[i] = 1'b0;
        shadow_keys[i] = '0;
      end
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) size_reg <= cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(hash_lookup(s_axis_tdata[1:0], s_axis_tdata[32:2],
                                               s_axis_tdata[40:33]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = lpht_pkg::status_t'(m_axis_tdata[2:0]);
        got.slot = m_axis_tdata[10:3];
        got.entry_key = m_axis_tdata[41:11];
        got.entry_valid = m_axis_tdata[42];
        bad = 1'b0;
        if (expected_results.size() == 0) begin
          $error("result with no expectation: %h", m_axis_tdata);
          bad = 1'b1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, got.status);
            bad = 1'b1;
          end
          if (got.slot !== exp_r.slot) begin
            $error("slot: expected %0d actual %0d", exp_r.slot, got.slot);
            bad = 1'b1;
          end
          if (got.entry_key !== exp_r.entry_key) begin
            $error("entry_key: expected %0d actual %0d", exp_r.entry_key, got.entry_key);
            bad = 1'b1;
          end
          if (got.entry_valid !== exp_r.entry_valid) begin
            $error("entry_valid: expected %0d actual %0d", exp_r.entry_valid,
                   got.entry_valid);
            bad = 1'b1;
          end
        end
        if (bad) fail_count <= fail_count + 1;
      end
    end
  end
endmodule

// ===== verif/tb_top.sv =====
// stimulus and verdict for the linear probing hash table
`timescale 1ns / 1ps
module tb_top;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;
  logic [lpht_pkg::KEY_W-1:0] recent_keys [$];

  always #5 clk = ~clk;

  linear_probe_hash_table_top dut (.*);
  lpht_checker checker_i (.*);

  // receiver stalls
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // send one item and wait for its handshake
  task automatic send_op(logic [1:0] mode, logic [lpht_pkg::KEY_W-1:0] key,
                         logic [7:0] rslot);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_axis_tdata <= {7'b0, rslot, key, mode};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    if (mode == lpht_pkg::OP_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
  endtask

  // wait until every result is in, then let the block settle and write size
  task automatic write_size(logic [8:0] value);
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random mix: mostly inserts and searches of known keys, small key ranges
  task automatic random_ops(int count, int key_span);
    logic [1:0] mode;
    logic [lpht_pkg::KEY_W-1:0] key;
    for (int i = 0; i < count; i++) begin
      mode = 2'($urandom_range(3));
      if ($urandom_range(9) < 4) mode = lpht_pkg::OP_INSERT;
      if (mode == lpht_pkg::OP_SEARCH && recent_keys.size() != 0 &&
          $urandom_range(3) != 0)
        key = recent_keys[$urandom_range(recent_keys.size() - 1)];
      else if ($urandom_range(9) == 0) key = lpht_pkg::KEY_W'($urandom);
      else key = lpht_pkg::KEY_W'($urandom_range(key_span));
      send_op(mode, key, 8'($urandom));
    end
  endtask

  initial begin
    int sizes [8] = '{256, 1, 0, 7, 300, 255, 16, 100};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    // directed part
    send_op(lpht_pkg::OP_INSERT, '1, 8'd0);
    send_op(lpht_pkg::OP_INSERT, 31'd255, 8'd0);
    send_op(lpht_pkg::OP_INSERT, 31'd0, 8'd0);
    send_op(lpht_pkg::OP_INSERT, 31'd256, 8'd0);
    send_op(lpht_pkg::OP_SEARCH, '1, 8'd0);
    send_op(lpht_pkg::OP_SEARCH, 31'd256, 8'd0);
    send_op(lpht_pkg::OP_SEARCH, 31'd12345, 8'd0);
    send_op(lpht_pkg::OP_READ, 31'd0, 8'd255);
    send_op(lpht_pkg::OP_READ, 31'd0, 8'd1);
    send_op(2'd3, '1, 8'd0);
    send_op(lpht_pkg::OP_READ, 31'd0, 8'd77);
    write_size(9'd2);
    send_op(lpht_pkg::OP_INSERT, 31'd5, 8'd0);
    send_op(lpht_pkg::OP_INSERT, 31'd5, 8'd0);
    send_op(lpht_pkg::OP_INSERT, 31'd5, 8'd0);
    send_op(lpht_pkg::OP_SEARCH, 31'd5, 8'd0);
    send_op(lpht_pkg::OP_SEARCH, 31'd9, 8'd0);
    send_op(lpht_pkg::OP_READ, 31'd0, 8'd1);
    // pause until all results are in
    while (pending_count != 0) @(negedge clk);
    // random phases over sizes and idling modes
    for (int ph = 0; ph < 8; ph++) begin
      write_size(9'(sizes[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      random_ops(141, (ph % 2) ? 600 : 40);
    end
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/lpht_pkg.sv
hdl/lpht_ram.sv
hdl/lpht_front.sv
hdl/lpht_queue.sv
hdl/lpht_back.sv
hdl/linear_probe_hash_table_top.sv
verif/lpht_checker.sv
verif/tb_top.sv
